>>> rtl/flba_pkg.sv
// Types and constants shared by the free-list block allocator.
// No dependencies; compile first.
package flba_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = 8;
    localparam int LINK_W     = 9;
    localparam int COUNT_W    = 9;

    localparam logic [LINK_W-1:0]  NULL_LINK = LINK_W'(MAX_BLOCKS);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_FREE    = 2'd1,
        MODE_REBUILD = 2'd2,
        MODE_NOP     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_RANGE     = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

    typedef struct packed {
        mode_t             mode;
        logic [IDX_W-1:0]  block_index;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [IDX_W-1:0]   granted_index;
        logic [COUNT_W-1:0] free_blocks;
    } out_item_t;

    // One request to the link memory per cycle.
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [LINK_W-1:0] wr_data;
        logic              clear;
    } link_req_t;

endpackage

>>> rtl/free_list_block_allocator_core.sv
// Top level of the free-list block allocator: control, head and count registers,
// result register. Depends on flba_pkg and flba_link_ram.
//
// The block hands out and takes back block indices of a pool as a LIFO free
// list. Each input transfer carries a mode: allocate pops the head index (or
// returns status exhausted), free pushes block_index (status out of range when
// the index is at or above block_count, with nothing changed), rebuild relinks
// blocks 0 .. block_count-1 with the highest handed out first. Mode 3 does
// nothing. Every input transfer yields exactly one result transfer with the
// status, the granted index (0 unless an allocate succeeds) and the free count.
// Free, rebuild, no-op and exhausted allocate items are answered from the idle state;
// an allocate that finds a block also passes through the pop state, where no new item
// is taken, to wait for the registered read of the link memory holding the next pointers.
// A rebuild clears all of the memory's valid bits at once, since unwritten
// entries read as their rebuilt value; there is no clearing pass after reset.
// block_count (0 acts as 1, above 256 acts as 256) is written on the cfg
// channel, always ready; write it only while the block is idle, which the block does not enforce.
// It takes effect at once for the range check and at the next rebuild for the list.
module free_list_block_allocator_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  flba_pkg::in_item_t             s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output flba_pkg::out_item_t            m_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [flba_pkg::COUNT_W-1:0]   cfg_data
);

    flba_pkg::state_t            state_reg, state_next;
    logic [flba_pkg::LINK_W-1:0]  head_reg, head_next;
    logic [flba_pkg::COUNT_W-1:0] total_reg, total_next;
    logic [flba_pkg::COUNT_W-1:0] bc_reg;
    flba_pkg::out_item_t         out_reg, out_next;
    logic                        out_valid_reg;
    logic                        out_load;
    logic                        in_xfer;
    logic [flba_pkg::COUNT_W-1:0] eff_count;
    logic [flba_pkg::LINK_W-1:0]  rd_link;
    flba_pkg::link_req_t         link_req;

    flba_link_ram u_link_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (link_req),
        .rd_link (rd_link)
    );

    // Clamp the configured count into 1 .. MAX_BLOCKS.
    always_comb begin
        if (bc_reg == '0) begin
            eff_count = flba_pkg::COUNT_W'(1);
        end else if (bc_reg > flba_pkg::COUNT_W'(flba_pkg::MAX_BLOCKS)) begin
            eff_count = flba_pkg::COUNT_W'(flba_pkg::MAX_BLOCKS);
        end else begin
            eff_count = bc_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_reg;

    // Take a new item only when idle and the result slot is free or draining.
    assign s_ready = (state_reg == flba_pkg::ST_IDLE) && (!out_valid_reg || m_ready);
    assign in_xfer = s_valid && s_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            flba_pkg::ST_IDLE: begin
                if (in_xfer && s_item.mode == flba_pkg::MODE_ALLOC
                        && !head_reg[flba_pkg::IDX_W]) begin
                    state_next = flba_pkg::ST_POP;
                end
            end
            flba_pkg::ST_POP: begin
                state_next = flba_pkg::ST_IDLE;
            end
            default: begin
                state_next = flba_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: memory request, head/count update, result load.
    always_comb begin
        link_req   = '0;
        head_next  = head_reg;
        total_next = total_reg;
        out_load   = 1'b0;
        out_next   = out_reg;
        unique case (state_reg)
            flba_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    out_load               = 1'b1;
                    out_next.status        = flba_pkg::STAT_OK;
                    out_next.granted_index = '0;
                    out_next.free_blocks   = total_reg;
                    case (s_item.mode)
                        flba_pkg::MODE_ALLOC: begin
                            if (head_reg[flba_pkg::IDX_W]) begin
                                out_next.status = flba_pkg::STAT_EXHAUSTED;
                            end else begin
                                // Result follows once the link comes back.
                                out_load         = 1'b0;
                                link_req.rd_en   = 1'b1;
                                link_req.rd_addr = head_reg[flba_pkg::IDX_W-1:0];
                            end
                        end
                        flba_pkg::MODE_FREE: begin
                            if ({1'b0, s_item.block_index} >= eff_count) begin
                                out_next.status = flba_pkg::STAT_RANGE;
                            end else begin
                                link_req.wr_en   = 1'b1;
                                link_req.wr_addr = s_item.block_index;
                                link_req.wr_data = head_reg;
                                head_next        = {1'b0, s_item.block_index};
                                if (total_reg != flba_pkg::COUNT_MAX) begin
                                    total_next = total_reg + 1'b1;
                                end
                                out_next.free_blocks = total_next;
                            end
                        end
                        flba_pkg::MODE_REBUILD: begin
                            link_req.clear       = 1'b1;
                            head_next            = eff_count - 1'b1;
                            total_next           = eff_count;
                            out_next.free_blocks = eff_count;
                        end
                        default: begin
                            // no-op: report the count
                        end
                    endcase
                end
            end
            flba_pkg::ST_POP: begin
                head_next = rd_link;
                if (total_reg != '0) begin
                    total_next = total_reg - 1'b1;
                end
                out_load               = 1'b1;
                out_next.status        = flba_pkg::STAT_OK;
                out_next.granted_index = head_reg[flba_pkg::IDX_W-1:0];
                out_next.free_blocks   = total_next;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= flba_pkg::ST_IDLE;
            head_reg      <= flba_pkg::LINK_W'(flba_pkg::MAX_BLOCKS - 1);
            total_reg     <= flba_pkg::COUNT_W'(flba_pkg::MAX_BLOCKS);
            bc_reg        <= flba_pkg::COUNT_W'(flba_pkg::MAX_BLOCKS);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            total_reg <= total_next;
            if (cfg_valid && cfg_ready) begin
                bc_reg <= cfg_data;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: hold until loaded again.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= out_next;
        end
    end

endmodule

>>> rtl/flba_link_ram.sv
// Link memory of the free list: one synchronous read port, one write port,
// per-entry valid bits. Depends on flba_pkg.
module flba_link_ram (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  flba_pkg::link_req_t           req,
    output logic [flba_pkg::LINK_W-1:0]   rd_link
);

    logic [flba_pkg::LINK_W-1:0] mem [flba_pkg::MAX_BLOCKS];
    logic [flba_pkg::MAX_BLOCKS-1:0] valid_reg;
    logic [flba_pkg::LINK_W-1:0] data_reg;
    logic                        hit_reg;
    logic [flba_pkg::IDX_W-1:0]  addr_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            data_reg <= mem[req.rd_addr];
            addr_reg <= req.rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end else begin
            if (req.clear) begin
                valid_reg <= '0;
            end else if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                hit_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // An entry never written since the last rebuild links to the block below.
    always_comb begin
        if (hit_reg) begin
            rd_link = data_reg;
        end else if (addr_reg == '0) begin
            rd_link = flba_pkg::NULL_LINK;
        end else begin
            rd_link = {1'b0, addr_reg - 1'b1};
        end
    end

endmodule

>>> rtl/flba_checker.sv
// Port-level assertions for the free-list block allocator, bound to the top.
// Depends on flba_pkg and free_list_block_allocator_core.
module flba_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  flba_pkg::in_item_t   s_item,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  flba_pkg::out_item_t  m_item
);

    // A rebuild is reported next cycle as ok with a nonzero count.
    a_rebuild_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.mode == flba_pkg::MODE_REBUILD |=>
        m_valid && m_item.status == flba_pkg::STAT_OK && m_item.free_blocks != '0)
        else $error("rebuild result missing or wrong");

    // A free never reports exhaustion and its result appears next cycle.
    a_free_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.mode == flba_pkg::MODE_FREE |=>
        m_valid && m_item.status != flba_pkg::STAT_EXHAUSTED)
        else $error("free result missing or wrong status");

    // Failed operations grant nothing.
    a_fail_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status != flba_pkg::STAT_OK |-> m_item.granted_index == '0)
        else $error("granted index on failed item");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

endmodule

bind free_list_block_allocator_core flba_checker u_flba_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

>>> tb/sv/tb_free_list_block_allocator_core.sv
// Self-checking testbench for free_list_block_allocator_core: directed and random
// allocate, free, rebuild and no-op traffic checked against a built-in free-list model.
// Depends on flba_pkg and the allocator RTL; needs no other files.
module tb_free_list_block_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import flba_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [COUNT_W-1:0] cfg_data;

    free_list_block_allocator_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Free-list model: link memory, head pointer, free count and the count register.
    logic [LINK_W-1:0]  pool_link [MAX_BLOCKS];
    logic [LINK_W-1:0]  pool_head;
    logic [COUNT_W-1:0] pool_free;
    logic [COUNT_W-1:0] pool_limit;

    // Results predicted for accepted transfers, oldest first.
    out_item_t due_results[$];

    int mismatches;
    int cycle_count;

    // Idling controls: idle_en enables random bursts on both sides; hold_left is a
    // long receiver hold-off that the ready process counts down on its own.
    bit idle_en;
    int hold_left;
    int stall_left;

    // Indices the random stimulus currently holds as allocated.
    logic [IDX_W-1:0] held_blocks[$];

    // Clamp the count register to 1 .. MAX_BLOCKS, as the block does wherever it is used.
    function automatic int usable_blocks();
        if (pool_limit == 0)
            return 1;
        if (int'(pool_limit) > MAX_BLOCKS)
            return MAX_BLOCKS;
        return int'(pool_limit);
    endfunction

    // Relink the pool so the highest usable block comes out first.
    function automatic void relink_pool();
        int n;
        n = usable_blocks();
        pool_link[0] = NULL_LINK;
        for (int i = 1; i < MAX_BLOCKS; i++)
            pool_link[i] = LINK_W'(i - 1);
        pool_head = LINK_W'(n - 1);
        pool_free = COUNT_W'(n);
    endfunction

    // Apply one item to the model and return the result it must produce.
    function automatic out_item_t predict_result(in_item_t it);
        out_item_t r;
        r.status        = STAT_OK;
        r.granted_index = '0;
        case (it.mode)
            MODE_ALLOC: begin
                if (pool_head >= NULL_LINK) begin
                    r.status = STAT_EXHAUSTED;
                end else begin
                    r.granted_index = pool_head[IDX_W-1:0];
                    pool_head       = pool_link[pool_head[IDX_W-1:0]];
                    // The count floors at zero; a double free can leave blocks
                    // on a cyclic list after the count has run out.
                    if (pool_free != 0)
                        pool_free = pool_free - 1'b1;
                end
            end
            MODE_FREE: begin
                if (int'(it.block_index) >= usable_blocks()) begin
                    r.status = STAT_RANGE;
                end else begin
                    pool_link[it.block_index] = pool_head;
                    pool_head = {1'b0, it.block_index};
                    if (pool_free != COUNT_MAX)
                        pool_free = pool_free + 1'b1;
                end
            end
            MODE_REBUILD: relink_pool();
            default: ;
        endcase
        r.free_blocks = pool_free;
        return r;
    endfunction

    function automatic in_item_t make_item(mode_t m, logic [IDX_W-1:0] idx);
        in_item_t it;
        it.mode        = m;
        it.block_index = idx;
        return it;
    endfunction

    // Clock and the cycle limit.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, due_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Result receiver: long hold-off first, then random stall bursts, else ready.
    initial begin
        m_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready = 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 12);
                m_ready = 1'b0;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Check every result transfer against the oldest prediction.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Unexpected result: status %0d granted %0d free %0d",
                             m_item.status, m_item.granted_index, m_item.free_blocks);
            end else begin
                want = due_results.pop_front();
                if (m_item.status !== want.status
                        || m_item.granted_index !== want.granted_index
                        || m_item.free_blocks !== want.free_blocks) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("Mismatch at cycle %0d", cycle_count);
                        $display("  expected status %0d granted %0d free %0d",
                                 want.status, want.granted_index, want.free_blocks);
                        $display("  got      status %0d granted %0d free %0d",
                                 m_item.status, m_item.granted_index,
                                 m_item.free_blocks);
                    end
                end
            end
        end
    end

    // Send one item: an optional idle burst, then hold valid until the transfer.
    task automatic send_item(in_item_t it, output out_item_t want);
        int gap;
        in_item_t junk;
        gap = 0;
        if (idle_en && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 13);
        if (gap > 0) begin
            junk.mode        = mode_t'(2'($urandom));
            junk.block_index = IDX_W'($urandom);
            @(negedge aclk);
            s_valid = 1'b0;
            s_item  = junk;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_item  = it;
        do @(posedge aclk); while (!s_ready);
        want = predict_result(it);
        due_results.push_back(want);
    endtask

    task automatic send(mode_t m, logic [IDX_W-1:0] idx);
        out_item_t want;
        send_item(make_item(m, idx), want);
    endtask

    // Drop valid and wait until every predicted result has come out.
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write the count register, only with the block idle.
    task automatic set_block_count(logic [COUNT_W-1:0] value);
        drain();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        pool_limit = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // State right after reset: 256 blocks, highest first, and a no-op.
    task automatic test_reset_state();
        send(MODE_ALLOC, 8'h00);
        send(MODE_ALLOC, 8'hFF);
        send(MODE_ALLOC, 8'h5A);
        send(MODE_FREE, 8'hFF);
        send(MODE_FREE, 8'h00);
        send(MODE_NOP, 8'hA5);
        send(MODE_ALLOC, 8'h00);
        send(MODE_ALLOC, 8'h00);
    endtask

    // Count extremes, clamping, exhaustion, out-of-range and double frees.
    task automatic test_count_limits();
        set_block_count(9'd1);
        send(MODE_REBUILD, 8'h00);
        send(MODE_ALLOC, 8'h00);
        send(MODE_ALLOC, 8'h00);      // pool exhausted
        send(MODE_FREE, 8'hFF);       // out of range
        send(MODE_FREE, 8'h01);
        send(MODE_FREE, 8'h00);
        send(MODE_FREE, 8'h00);       // double free closes a cycle on block 0
        send(MODE_ALLOC, 8'h00);
        send(MODE_ALLOC, 8'h00);
        send(MODE_ALLOC, 8'h00);      // count floors at zero, list still yields 0
        set_block_count(9'd0);        // acts as one
        send(MODE_FREE, 8'h01);
        send(MODE_REBUILD, 8'hFF);
        set_block_count(9'h1FF);      // acts as 256; range check changes at once
        send(MODE_FREE, 8'hFF);
        send(MODE_REBUILD, 8'h00);
        send(MODE_ALLOC, 8'h00);
        set_block_count(9'd3);        // no rebuild: list keeps its old blocks
        send(MODE_FREE, 8'd200);
        send(MODE_ALLOC, 8'h00);
        send(MODE_NOP, 8'h00);
    endtask

    // Empty the full pool, then overfill the count until it saturates.
    task automatic test_full_pool();
        set_block_count(9'd256);
        send(MODE_REBUILD, 8'h00);
        repeat (257) send(MODE_ALLOC, IDX_W'($urandom));
        send(MODE_REBUILD, 8'h00);
        repeat (260) send(MODE_FREE, IDX_W'($urandom));
        send(MODE_ALLOC, 8'h00);
    endtask

    // Hold the receiver off for a long stretch while items keep coming.
    task automatic test_backpressure();
        drain();
        idle_en = 1'b0;
        @(posedge aclk);
        hold_left = 400;
        send(MODE_REBUILD, 8'h00);
        repeat (60) begin
            if ($urandom_range(0, 1) == 0)
                send(MODE_ALLOC, IDX_W'($urandom));
            else
                send(MODE_FREE, IDX_W'($urandom));
        end
        drain();
    endtask

    // Random phases: mostly well-formed alloc/free pairs on held blocks, plus noise.
    task automatic test_random_traffic();
        int pick;
        int pos;
        logic [COUNT_W-1:0] count;
        out_item_t want;
        in_item_t it;
        for (int phase = 0; phase < 12; phase++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                count = COUNT_W'($urandom_range(1, 16));
            else if (pick < 8)
                count = COUNT_W'($urandom_range(17, 256));
            else if (pick == 8)
                count = COUNT_W'($urandom_range(257, 511));
            else
                count = ($urandom_range(0, 1) == 0) ? 9'd1 : 9'd256;
            set_block_count(count);
            // Leave the last phase free of idling on both sides.
            idle_en = (phase < 11) && ($urandom_range(0, 3) != 0);
            held_blocks.delete();
            send(MODE_REBUILD, IDX_W'($urandom));
            repeat (90) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    it = make_item(MODE_ALLOC, IDX_W'($urandom));
                end else if (pick < 85 && held_blocks.size() != 0) begin
                    pos = $urandom_range(0, held_blocks.size() - 1);
                    it  = make_item(MODE_FREE, held_blocks[pos]);
                    held_blocks.delete(pos);
                end else if (pick < 92) begin
                    it = make_item(MODE_FREE, IDX_W'($urandom));
                end else if (pick < 96) begin
                    it = make_item(MODE_NOP, IDX_W'($urandom));
                end else begin
                    it = make_item(MODE_REBUILD, IDX_W'($urandom));
                end
                send_item(it, want);
                if (it.mode == MODE_REBUILD)
                    held_blocks.delete();
                else if (it.mode == MODE_ALLOC && want.status == STAT_OK)
                    held_blocks.push_back(want.granted_index);
            end
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_item     = make_item(MODE_ALLOC, 8'h00);
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        mismatches = 0;
        hold_left  = 0;
        idle_en    = 1'b1;
        pool_limit = 9'd256;
        relink_pool();
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_state();
        test_count_limits();
        test_full_pool();
        test_backpressure();
        idle_en = 1'b1;
        test_random_traffic();

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
